/* rtl/core/spms_pkg.sv */
`default_nettype none

package spms_pkg;

  localparam int MAX_CLASSES = 4;
  localparam int CAPACITY    = 16;
  localparam int DATA_WIDTH  = 32;

  localparam int CLASS_W = $clog2(MAX_CLASSES);
  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int DEPTH_W = $clog2(CAPACITY + 1);
  localparam int ADDR_W  = CLASS_W + SLOT_W;
  localparam int DEPTH   = MAX_CLASSES * CAPACITY;

  localparam int PRIO_W    = 8;
  localparam int NCLS_W    = 3;
  localparam int LIMIT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [NCLS_W-1:0]  CLASSES_RESET = 3'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASSES_IN_USE = 1'b0,
    CFG_TOTAL_LIMIT    = 1'b1
  } spms_cfg_idx_t;

  typedef enum logic [0:0] {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } spms_action_t;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } spms_status_t;

  typedef struct packed {
    spms_action_t            action;
    logic [PRIO_W-1:0]       priority_class;
    logic [DATA_WIDTH-1:0]   entry_data;
  } spms_in_t;

  typedef struct packed {
    spms_status_t            status;
    logic [DATA_WIDTH-1:0]   popped_data;
    logic [CLASS_W-1:0]      popped_class;
    logic [DEPTH_W-1:0]      stored_count;
  } spms_out_t;

endpackage

`default_nettype wire

/* rtl/core/strict_priority_multi_stack.sv */
// Strict-priority multi-stack with a shared entry limit. A word is taken at
// every clock edge at which start is high; busy is always low, so a new word
// can follow in every cycle. Each word gives exactly one result, shown on
// out_word with out_strobe high for one cycle, in the cycle after the word was
// taken. The read of the entry memory is registered. The receiver cannot stall
// the block and must take every result. Configuration writes through cfg_we
// take effect at once and are meant only while no result is pending.
`default_nettype none

module strict_priority_multi_stack (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire spms_pkg::spms_in_t                  in_word,
  output      logic                                out_strobe,
  output      spms_pkg::spms_out_t                 out_word,
  input  wire logic                                cfg_we,
  input  wire logic [spms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [spms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [spms_pkg::NCLS_W-1:0]     classes_r;
  logic [spms_pkg::LIMIT_W-1:0]    limit_r;
  logic [spms_pkg::DEPTH_W-1:0]    depth_r   [spms_pkg::MAX_CLASSES];
  logic [spms_pkg::DEPTH_W-1:0]    depth_nxt [spms_pkg::MAX_CLASSES];
  logic [spms_pkg::DEPTH_W-1:0]    count_r;
  logic [spms_pkg::DEPTH_W-1:0]    count_nxt;

  logic                            strobe_r;
  spms_pkg::spms_status_t          status_r;
  spms_pkg::spms_status_t          status_nxt;
  logic [spms_pkg::CLASS_W-1:0]    class_r;
  logic [spms_pkg::CLASS_W-1:0]    class_nxt;
  logic [spms_pkg::DATA_WIDTH-1:0] rd_data_r;

  logic [spms_pkg::DATA_WIDTH-1:0] mem [spms_pkg::DEPTH];

  logic                            accept;
  logic [spms_pkg::NCLS_W-1:0]     ncls;
  logic [spms_pkg::DEPTH_W-1:0]    lim;
  logic [spms_pkg::CLASS_W-1:0]    push_cls;
  logic [spms_pkg::DEPTH_W-1:0]    push_depth;
  logic                            push_ok;
  logic                            pop_found;
  logic [spms_pkg::CLASS_W-1:0]    pop_cls;
  logic [spms_pkg::DEPTH_W-1:0]    pop_depth;
  logic                            pop_ok;
  logic [spms_pkg::ADDR_W-1:0]     wr_addr;
  logic [spms_pkg::ADDR_W-1:0]     rd_addr;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    if (classes_r == '0) begin
      ncls = spms_pkg::NCLS_W'(1);
    end else if (classes_r > spms_pkg::NCLS_W'(spms_pkg::MAX_CLASSES)) begin
      ncls = spms_pkg::NCLS_W'(spms_pkg::MAX_CLASSES);
    end else begin
      ncls = classes_r;
    end
    if (limit_r > spms_pkg::LIMIT_W'(spms_pkg::CAPACITY)) begin
      lim = spms_pkg::DEPTH_W'(spms_pkg::CAPACITY);
    end else begin
      lim = spms_pkg::DEPTH_W'(limit_r);
    end
  end

  always_comb begin
    if (in_word.priority_class >= spms_pkg::PRIO_W'(ncls)) begin
      push_cls = '0;
    end else begin
      push_cls = in_word.priority_class[spms_pkg::CLASS_W-1:0];
    end
    push_depth = depth_r[push_cls];
    push_ok    = (count_r < lim) &&
                 (push_depth < spms_pkg::DEPTH_W'(spms_pkg::CAPACITY));
    wr_addr    = {push_cls, push_depth[spms_pkg::SLOT_W-1:0]};
  end

  // The lowest-numbered class in use that holds an entry wins the pop.
  always_comb begin
    pop_found = 1'b0;
    pop_cls   = '0;
    for (int i = 0; i < spms_pkg::MAX_CLASSES; i++) begin
      if (!pop_found && (spms_pkg::NCLS_W'(i) < ncls) && (depth_r[i] != '0)) begin
        pop_found = 1'b1;
        pop_cls   = spms_pkg::CLASS_W'(i);
      end
    end
    pop_depth = depth_r[pop_cls] - spms_pkg::DEPTH_W'(1);
    pop_ok    = pop_found;
    rd_addr   = {pop_cls, pop_depth[spms_pkg::SLOT_W-1:0]};
  end

  always_comb begin
    for (int i = 0; i < spms_pkg::MAX_CLASSES; i++) begin
      depth_nxt[i] = depth_r[i];
    end
    count_nxt = count_r;
    class_nxt = '0;
    if (in_word.action == spms_pkg::ACT_ENQUEUE) begin
      if (push_ok) begin
        status_nxt          = spms_pkg::ST_STORED;
        depth_nxt[push_cls] = push_depth + spms_pkg::DEPTH_W'(1);
        count_nxt           = count_r + spms_pkg::DEPTH_W'(1);
      end else begin
        status_nxt = spms_pkg::ST_DROPPED;
      end
    end else begin
      if (pop_ok) begin
        status_nxt         = spms_pkg::ST_POPPED;
        class_nxt          = pop_cls;
        depth_nxt[pop_cls] = pop_depth;
        count_nxt          = count_r - spms_pkg::DEPTH_W'(1);
      end else begin
        status_nxt = spms_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      classes_r <= spms_pkg::CLASSES_RESET;
      limit_r   <= spms_pkg::LIMIT_RESET;
      for (int i = 0; i < spms_pkg::MAX_CLASSES; i++) begin
        depth_r[i] <= '0;
      end
      count_r  <= '0;
      strobe_r <= 1'b0;
      status_r <= spms_pkg::ST_STORED;
      class_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spms_pkg::CFG_CLASSES_IN_USE: classes_r <= cfg_wdata[spms_pkg::NCLS_W-1:0];
          spms_pkg::CFG_TOTAL_LIMIT:    limit_r   <= cfg_wdata[spms_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      strobe_r <= accept;
      if (accept) begin
        for (int i = 0; i < spms_pkg::MAX_CLASSES; i++) begin
          depth_r[i] <= depth_nxt[i];
        end
        count_r  <= count_nxt;
        status_r <= status_nxt;
        class_r  <= class_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_word.action == spms_pkg::ACT_ENQUEUE) && push_ok) begin
      mem[wr_addr] <= in_word.entry_data;
    end
    if (accept && (in_word.action == spms_pkg::ACT_DEQUEUE) && pop_ok) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_strobe            = strobe_r;
  assign out_word.status       = status_r;
  assign out_word.popped_data  = (status_r == spms_pkg::ST_POPPED) ? rd_data_r : '0;
  assign out_word.popped_class = class_r;
  assign out_word.stored_count = count_r;

endmodule

`default_nettype wire

/* rtl/core/spms_chk.sv */
`default_nettype none

module spms_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire spms_pkg::spms_in_t              in_word,
  input wire logic                            out_strobe,
  input wire spms_pkg::spms_out_t             out_word
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> out_strobe)
    else $error("accepted word gave no result in the next cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n))
    else $error("result without an accepted word");

  a_enqueue_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.action == spms_pkg::ACT_ENQUEUE)) |=>
      ((out_word.status == spms_pkg::ST_STORED) ||
       (out_word.status == spms_pkg::ST_DROPPED)))
    else $error("enqueue word gave a pop status");

  a_zero_unless_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_word.status != spms_pkg::ST_POPPED)) |->
      ((out_word.popped_data == '0) && (out_word.popped_class == '0)))
    else $error("popped fields not zero on a non-pop result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      (out_word.stored_count <= spms_pkg::DEPTH_W'(spms_pkg::CAPACITY)) &&
      ((out_word.status != spms_pkg::ST_STORED) || (out_word.stored_count != '0)))
    else $error("stored count out of range");

endmodule

bind strict_priority_multi_stack spms_chk u_spms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

`default_nettype wire
